[hw/rtl/ascfmt_pkg.sv]
// ----------------------------------------------------------------------------
// ascfmt_pkg
// Shared codes, widths, control/status bundles and the digit character map
// for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package ascfmt_pkg;

    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 5;
    localparam int BCD_W   = 80;   // 20 BCD digits hold any 64-bit value
    localparam int STEP_W  = 4;    // conversion step counter, four bits converted per step

    // format commands
    localparam logic [2:0] CMD_UDEC = 3'd0;
    localparam logic [2:0] CMD_SDEC = 3'd1;
    localparam logic [2:0] CMD_OCT  = 3'd2;
    localparam logic [2:0] CMD_HEXL = 3'd3;
    localparam logic [2:0] CMD_HEXU = 3'd4;
    localparam logic [2:0] CMD_PTR  = 3'd5;

    // digit counts per format
    localparam logic [CNT_W-1:0] DEC_DIGITS = 5'd20;
    localparam logic [CNT_W-1:0] HEX_DIGITS = 5'd16;
    localparam logic [CNT_W-1:0] OCT_DIGITS = 5'd22;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic conv;
        logic lead;
        logic xchr;
        logic digit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_dec;
        logic has_lead;
        logic has_xchr;
        logic conv_done;
        logic dig_last;
    } t_dp_sts;

    // 0-9, a-f / A-F
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base;
        begin
            if (d < 4'd10) begin
                digit_char = CH_ZERO + {4'h0, d};
            end else begin
                base = upper ? CH_A_UP : CH_A_LO;
                digit_char = base + {4'h0, d - 4'd10};
            end
        end
    endfunction

endpackage

[hw/rtl/ascfmt_ctrl.sv]
// ----------------------------------------------------------------------------
// ascfmt_ctrl
// Sequencer: setup, decimal conversion, leading characters, digit emission.
// ----------------------------------------------------------------------------
module ascfmt_ctrl
    import ascfmt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_CONV  = 6'b000100,
        S_LEAD  = 6'b001000,
        S_XCHR  = 6'b010000,
        S_DIGIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_PREP;
            end
            S_PREP: begin
                if (i_sts.is_dec)        n_state = S_CONV;
                else if (i_sts.has_lead) n_state = S_LEAD;
                else                     n_state = S_DIGIT;
            end
            S_CONV: begin
                if (i_sts.conv_done) begin
                    n_state = i_sts.has_lead ? S_LEAD : S_DIGIT;
                end
            end
            S_LEAD: begin
                n_state = i_sts.has_xchr ? S_XCHR : S_DIGIT;
            end
            S_XCHR: begin
                n_state = S_DIGIT;
            end
            S_DIGIT: begin
                if (i_sts.dig_last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.load  = (r_state == S_IDLE) && i_start;
        o_cmd.conv  = (r_state == S_CONV);
        o_cmd.lead  = (r_state == S_LEAD);
        o_cmd.xchr  = (r_state == S_XCHR);
        o_cmd.digit = (r_state == S_DIGIT);
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[hw/rtl/ascfmt_dp.sv]
// ----------------------------------------------------------------------------
// ascfmt_dp
// Digit register, binary to BCD shift-and-add-3 unit, character selection
// and the registered result stage.
// ----------------------------------------------------------------------------
module ascfmt_dp
    import ascfmt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [2:0]         i_command,
    input  logic               i_alt_flag,
    input  logic               i_width_zero,
    output t_dp_sts            o_sts,
    output logic               o_strobe,
    output logic [CHAR_W-1:0]  o_char_out,
    output logic               o_last,
    output logic               o_prefix_added
);

    logic [BCD_W-1:0]   r_dig;
    logic [VALUE_W-1:0] r_bin;
    logic [CNT_W-1:0]   r_cnt;
    logic [STEP_W-1:0]  r_step;
    logic               r_dec;
    logic               r_oct;
    logic               r_upper;
    logic               r_pre;
    logic               r_neg;
    logic               r_seen;

    logic               r_out_vld;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;
    logic               r_out_pre;

    // command decode at load
    logic               is_oct;
    logic               is_hex;
    logic               ld_neg;
    logic               ld_pre;
    logic [VALUE_W-1:0] ld_mag;

    always_comb begin
        is_oct = (i_command == CMD_OCT);
        is_hex = (i_command == CMD_HEXL) || (i_command == CMD_HEXU) ||
                 (i_command == CMD_PTR);
        ld_neg = (i_command == CMD_SDEC) && i_value[VALUE_W-1];
        ld_pre = ((i_command == CMD_PTR) || i_alt_flag) && i_width_zero &&
                 (is_oct || is_hex);
        ld_mag = ld_neg ? (~i_value + 64'd1) : i_value;
    end

    // four shift-and-add-3 steps per cycle
    logic [BCD_W-1:0]   bcd_w;
    logic [VALUE_W-1:0] bin_w;

    always_comb begin
        bcd_w = r_dig;
        bin_w = r_bin;
        for (int s = 0; s < 4; s++) begin
            for (int d = 0; d < BCD_W / 4; d++) begin
                if (bcd_w[d*4 +: 4] >= 4'd5) begin
                    bcd_w[d*4 +: 4] = bcd_w[d*4 +: 4] + 4'd3;
                end
            end
            {bcd_w, bin_w} = {bcd_w[BCD_W-2:0], bin_w, 1'b0};
        end
    end

    // top digit of the register
    logic [3:0] top_dig;
    logic       dig_skip;

    assign top_dig  = r_oct ? {1'b0, r_dig[BCD_W-1 -: 3]} : r_dig[BCD_W-1 -: 4];
    // leading zeros are dropped, but never the final digit
    assign dig_skip = (top_dig == 4'd0) && !r_seen && (r_cnt != 5'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dec   <= !(is_oct || is_hex);
            r_oct   <= is_oct;
            r_upper <= (i_command == CMD_HEXU);
            r_pre   <= ld_pre;
            r_neg   <= ld_neg;
            r_bin   <= ld_mag;
            r_step  <= '0;
            r_seen  <= 1'b0;
            if (is_hex) begin
                r_dig <= {i_value, 16'h0};
                r_cnt <= HEX_DIGITS;
            end else if (is_oct) begin
                r_dig <= {2'b00, i_value, 14'h0};
                r_cnt <= OCT_DIGITS;
            end else begin
                r_dig <= '0;
                r_cnt <= DEC_DIGITS;
            end
        end else if (i_cmd.conv) begin
            r_dig  <= bcd_w;
            r_bin  <= bin_w;
            r_step <= r_step + 4'd1;
        end else if (i_cmd.digit) begin
            r_dig  <= r_oct ? {r_dig[BCD_W-4:0], 3'b000} : {r_dig[BCD_W-5:0], 4'h0};
            r_cnt  <= r_cnt - 5'd1;
            r_seen <= r_seen || (top_dig != 4'd0);
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.lead || i_cmd.xchr || (i_cmd.digit && !dig_skip);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pre  <= r_pre;
        r_out_last <= i_cmd.digit && (r_cnt == 5'd1);
        if (i_cmd.lead) begin
            r_out_char <= r_neg ? CH_MINUS : CH_ZERO;
        end else if (i_cmd.xchr) begin
            r_out_char <= r_upper ? CH_X_UP : CH_X_LO;
        end else begin
            r_out_char <= digit_char(top_dig, r_upper);
        end
    end

    always_comb begin
        o_sts.is_dec    = r_dec;
        o_sts.has_lead  = r_neg || r_pre;
        o_sts.has_xchr  = r_pre && !r_oct;
        o_sts.conv_done = (r_step == 4'hf);
        o_sts.dig_last  = (r_cnt == 5'd1);
    end

    assign o_strobe       = r_out_vld;
    assign o_char_out     = r_out_char;
    assign o_last         = r_out_last;
    assign o_prefix_added = r_out_pre;

endmodule

[hw/rtl/integer_to_ascii_formatter_unit.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats a 64-bit value as ASCII text, one character per strobe.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over a value and format command.
// The text comes out most significant character first, one character per
// o_strobe cycle, with o_last on the final one; the receiver cannot stall,
// so every strobed character must be captured in its cycle. Prefix or minus
// sign characters come first, then the digits with leading zeros dropped.
// Decimal values first pass through the binary to BCD unit, four bits per
// cycle, then the 20 digit positions are scanned with leading zero
// positions skipped silently; hex and octal have no conversion and go
// straight to the digit positions.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit
    import ascfmt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [2:0]         i_command,
    input  logic               i_alt_flag,
    input  logic               i_width_zero,
    output logic               o_strobe,
    output logic [CHAR_W-1:0]  o_char_out,
    output logic               o_last,
    output logic               o_prefix_added
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ascfmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    ascfmt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_value        (i_value),
        .i_command      (i_command),
        .i_alt_flag     (i_alt_flag),
        .i_width_zero   (i_width_zero),
        .o_sts          (dp_sts),
        .o_strobe       (o_strobe),
        .o_char_out     (o_char_out),
        .o_last         (o_last),
        .o_prefix_added (o_prefix_added)
    );

    // at most one datapath operation per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(dp_cmd))
        else $error("datapath commands overlap");

    // a character only appears as a result of work in the previous cycle
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("strobe without preceding activity");

    // the final character coincides with the unit going idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("last character while still busy");

    // an accepted start always launches work
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer not taken");

endmodule
